@@ hdl/rsm_pkg.sv @@
// Shared types, constants and helper functions of the rotor speed model.
`timescale 1ns / 1ps

package rsm_pkg;

    // Field and port widths
    localparam int THR_W      = 17;
    localparam int COLL_W     = 23;
    localparam int DESC_W     = 25;
    localparam int SPEED_W    = 29;
    localparam int TORQUE_W   = 32;
    localparam int RUNUP_W    = 20;
    localparam int S_DATA_W   = 72;
    localparam int M_DATA_W   = 64;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 40;

    // Square root unit: radicand is |collective| with 16 fraction bits appended
    localparam int SQ_IN_W  = 40;
    localparam int SQ_OUT_W = SQ_IN_W / 2;
    localparam int SQ_REM_W = SQ_OUT_W + 2;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_NOMINAL    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DRAG_IDLE  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DRAG_PITCH = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ENG_MAX    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_TICK       = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_GAS        = 3'd5;

    // Scale constants
    localparam logic signed [63:0] K_RADS    = 64'sd449541342;
    localparam logic signed [63:0] K_INV53   = 64'sd810371188;
    localparam logic signed [63:0] K_1P2     = 64'sd5153960755;
    localparam logic signed [63:0] K_0P333   = 64'sd1430224110;
    localparam logic signed [63:0] LIM61     = 64'sd2305843009213693952;
    localparam logic signed [63:0] LIM40     = 64'sd1099511627776;
    localparam logic signed [63:0] SPOOL_LIM = 64'sd19660800;
    localparam logic signed [63:0] SPOOL_DOT = -64'sd2621440;
    localparam logic signed [63:0] SPEED_MAX = 64'sd262144000;
    localparam logic signed [63:0] I32_MAX   = 64'sd2147483647;
    localparam logic signed [63:0] I32_MIN   = -64'sd2147483648;
    localparam logic [THR_W-1:0]   THR_ONE   = 17'd65536;
    localparam logic [THR_W-1:0]   THR_LOW   = 17'd9830;
    localparam logic [THR_W-1:0]   THR_HIGH  = 17'd16384;
    localparam logic signed [RUNUP_W-1:0] RUN_ONE = 20'sd65536;
    localparam logic [7:0] ACCEL_BASE = 8'd100;
    localparam logic [7:0] ACCEL_FAST = 8'd250;

    // Motor mode of the electric drive
    typedef enum logic [1:0] {
        MODE_NONE      = 2'd0,
        MODE_IDLE      = 2'd1,
        MODE_WINDOW    = 2'd2,
        MODE_UNLIMITED = 2'd3
    } mode_t;

    // Multiplier output shift
    typedef enum logic [1:0] {
        SH_0  = 2'd0,
        SH_16 = 2'd1,
        SH_32 = 2'd2,
        SH_40 = 2'd3
    } sh_t;

    typedef struct packed {
        logic start;
        sh_t  sh;
    } mul_req_t;

    // Multiply steps of the sequencer
    typedef enum logic [4:0] {
        OP_P, OP_T, OP_W, OP_W2, OP_ROTOR, OP_WN, OP_WN2, OP_AUTOT,
        OP_D1, OP_DESC, OP_G1, OP_GT, OP_LHS, OP_E1, OP_ENG, OP_HOLD,
        OP_RPM, OP_DELTA
    } op_t;

    function automatic logic signed [63:0] clamp_pm61(input logic signed [63:0] x);
        return (x < -LIM61) ? -LIM61 : ((x > LIM61) ? LIM61 : x);
    endfunction

    function automatic logic signed [63:0] clamp_0_61(input logic signed [63:0] x);
        return (x < 64'sd0) ? 64'sd0 : ((x > LIM61) ? LIM61 : x);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [63:0] y;
        y = (x < I32_MIN) ? I32_MIN : ((x > I32_MAX) ? I32_MAX : x);
        return y[31:0];
    endfunction

endpackage

@@ hdl/rsm_mul.sv @@
// Shared multi-cycle signed multiplier with rounding shift and saturation.
`timescale 1ns / 1ps

module rsm_mul
    import rsm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  mul_req_t            req,
    input  logic signed [63:0]  a,
    input  logic signed [63:0]  b,
    output logic                done,
    output logic signed [63:0]  result
);

    logic [63:0]  ua_reg, ub_reg;
    logic         neg_reg;
    logic [127:0] acc_reg;
    logic [2:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;
    sh_t          sh_reg;
    logic signed [63:0] result_reg;

    logic [31:0]  a_half, b_half;
    logic [63:0]  pp;
    logic [127:0] pp_placed;
    logic [127:0] rnd, sum_r, shifted;
    logic         sat;

    // Pick one 32x32 partial product per cycle
    always_comb
    begin
        a_half = cnt_reg[0] ? ua_reg[63:32] : ua_reg[31:0];
        b_half = cnt_reg[1] ? ub_reg[63:32] : ub_reg[31:0];
        pp     = a_half * b_half;
        case (cnt_reg[1:0])
            2'd0:    pp_placed = {64'd0, pp};
            2'd3:    pp_placed = {pp, 64'd0};
            default: pp_placed = {32'd0, pp, 32'd0};
        endcase
    end

    // Round half away from zero on the magnitude, shift and saturate
    always_comb
    begin
        case (sh_reg)
            SH_0:    rnd = 128'd0;
            SH_16:   rnd = 128'd1 << 15;
            SH_32:   rnd = 128'd1 << 31;
            SH_40:   rnd = 128'd1 << 39;
            default: rnd = 128'd0;
        endcase
        sum_r = acc_reg + rnd;
        case (sh_reg)
            SH_0:    shifted = sum_r;
            SH_16:   shifted = sum_r >> 16;
            SH_32:   shifted = sum_r >> 32;
            SH_40:   shifted = sum_r >> 40;
            default: shifted = sum_r;
        endcase
        sat = |shifted[127:63];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
            end
            else if (busy_reg)
            begin
                if (!cnt_reg[2])
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                end
                else
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand capture, accumulation and result
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            ua_reg  <= a[63] ? (64'd0 - a) : a;
            ub_reg  <= b[63] ? (64'd0 - b) : b;
            neg_reg <= a[63] ^ b[63];
            sh_reg  <= req.sh;
            acc_reg <= 128'd0;
        end
        else if (busy_reg)
        begin
            if (!cnt_reg[2])
            begin
                acc_reg <= acc_reg + pp_placed;
            end
            else if (sat)
            begin
                result_reg <= neg_reg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            end
            else
            begin
                result_reg <= neg_reg ? -$signed(shifted[63:0]) : $signed(shifted[63:0]);
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ hdl/rsm_sqrt.sv @@
// Iterative integer square root, one result bit per cycle.
`timescale 1ns / 1ps

module rsm_sqrt
    import rsm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [SQ_IN_W-1:0]  radicand,
    output logic                done,
    output logic [SQ_OUT_W-1:0] root
);

    localparam int CNT_W = $clog2(SQ_OUT_W + 1);

    logic [SQ_IN_W-1:0]  rad_reg;
    logic [SQ_REM_W-1:0] rem_reg;
    logic [SQ_OUT_W-1:0] root_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [SQ_REM_W+1:0] rem_sh, trial;
    logic                fits;

    // Bring down two bits and try the next root bit
    always_comb
    begin
        rem_sh = {rem_reg, rad_reg[SQ_IN_W-1 -: 2]};
        trial  = {2'b00, root_reg, 2'b01};
        fits   = (rem_sh >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQ_OUT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= fits ? SQ_REM_W'(rem_sh - trial) : SQ_REM_W'(rem_sh);
            root_reg <= {root_reg[SQ_OUT_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

@@ hdl/rotor_speed_model_top.sv @@
// Top level: rotor speed model with sequencer around a shared multiplier.
// Sequence per accepted word: the square root, then 11 to 15 multiplies on the shared 64x64
// multiplier (issue, four 32x32 partial products, a rounding step, hand-back), one decide,
// one output. s_tready is high only while idle, and a
// new word may be taken while the previous result still waits on m_tvalid.
// Reset: control state, speed, run-up, mode and configuration registers return to their
// defaults; the per-word working registers and the output data register are not reset.
`timescale 1ns / 1ps

module rotor_speed_model_top
    import rsm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // throttle, collective, descent_speed, zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // rotor_speed, drive torque, zero pad
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SQRT   = 6'b000010,
        S_ISSUE  = 6'b000100,
        S_WAIT   = 6'b001000,
        S_DECIDE = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg;

    // Configuration
    logic [11:0] nom_reg;
    logic [39:0] dic_reg, dpc_reg;
    logic [31:0] emax_reg, dt_reg;
    logic        gas_reg;

    // Persistent state
    logic signed [SPEED_W-1:0] curr_reg;
    logic signed [RUNUP_W-1:0] runup_reg;
    mode_t                     mode_reg;

    // Per-word working registers
    logic [THR_W-1:0]          thr_reg;
    logic [COLL_W-1:0]         c_reg;
    logic signed [DESC_W-1:0]  desc_reg;
    logic [SQ_OUT_W-1:0]       s_reg;
    logic [7:0]                accel_reg;
    logic signed [63:0] p_reg, drag_reg, w_reg, w2_reg, rotor_reg, wn_reg, wn2_reg;
    logic signed [63:0] autot_reg, tmp_reg, descent_reg, torque_reg, lhs_reg;
    logic signed [63:0] eng_reg, hold_reg, sum_reg, rpm_reg, delta_reg;

    // Output register
    logic                  m_tvalid_reg;
    logic [M_DATA_W-1:0]   m_tdata_reg;

    // Square root unit and shared multiplier
    mul_req_t           mreq;
    logic signed [63:0] mul_a, mul_b, mul_r;
    logic               mul_done;
    logic               sq_done;
    logic [SQ_OUT_W-1:0] sq_root;

    logic                      accept;
    logic [THR_W-1:0]          thr_in, thr_c;
    logic signed [COLL_W-1:0]  coll_in;
    logic [COLL_W-1:0]         c_mag;
    mode_t                     mode_next;
    logic [32:0]               inc_sum;
    logic [15:0]               inc;
    logic signed [23:0]        runup_wide;
    logic signed [RUNUP_W-1:0] runup_next;
    logic [7:0]                accel_next;

    logic signed [63:0] curr64, nom64, runup64, thr10;
    logic signed [63:0] hold_lim, accel_lim, rhs;
    logic               hold_cond, spool;
    logic signed [63:0] inp, sum_next;
    logic signed [63:0] dcl, speed_sum, speed_new;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);

    assign curr64  = {{(64-SPEED_W){curr_reg[SPEED_W-1]}}, curr_reg};
    assign nom64   = {52'd0, nom_reg};
    assign runup64 = {{(64-RUNUP_W){runup_reg[RUNUP_W-1]}}, runup_reg};
    assign thr10   = ({47'd0, thr_reg} <<< 3) + ({47'd0, thr_reg} <<< 1);

    // Clamp throttle, take the collective magnitude
    always_comb
    begin
        thr_in  = s_tdata[16:0];
        thr_c   = (thr_in > THR_ONE) ? THR_ONE : thr_in;
        coll_in = $signed(s_tdata[39:17]);
        c_mag   = coll_in[COLL_W-1] ? (COLL_W'(0) - coll_in) : coll_in;
    end

    // Advance motor mode and run-up level of the electric drive
    always_comb
    begin
        if (thr_c > THR_HIGH)
            mode_next = MODE_UNLIMITED;
        else if (mode_reg == MODE_UNLIMITED && thr_c > THR_LOW)
            mode_next = MODE_WINDOW;
        else if (thr_c <= THR_LOW)
            mode_next = MODE_IDLE;
        else
            mode_next = mode_reg;

        if (mode_next == MODE_WINDOW)
        begin
            inc_sum = {1'b0, dt_reg} + 33'd65536;
            inc     = 16'(inc_sum >> 17);
        end
        else
        begin
            inc_sum = {1'b0, dt_reg} + 33'd262144;
            inc     = 16'(inc_sum >> 19);
        end

        if (mode_next == MODE_UNLIMITED)
        begin
            if (runup_reg < RUN_ONE)
                runup_wide = 24'(runup_reg) + $signed({8'd0, inc});
            else
                runup_wide = 24'(RUN_ONE);
        end
        else
        begin
            if (runup_reg > 20'sd0)
                runup_wide = 24'(runup_reg) - $signed({5'd0, inc, 3'd0})
                             - $signed({7'd0, inc, 1'b0});
            else
                runup_wide = 24'sd0;
        end

        if (runup_wide < -24'sd524288)
            runup_next = -20'sd524288;
        else if (runup_wide > 24'sd524287)
            runup_next = 20'sd524287;
        else
            runup_next = runup_wide[RUNUP_W-1:0];

        accel_lim  = (nom64 - 64'sd25) <<< 16;
        accel_next = (mode_next == MODE_UNLIMITED && curr64 < accel_lim)
                     ? ACCEL_FAST : ACCEL_BASE;
    end

    // Operand select for the shared multiplier
    always_comb
    begin
        mreq.start = (state_reg == S_ISSUE);
        mul_a = 64'sd0;
        mul_b = 64'sd0;
        mreq.sh = SH_0;
        case (op_reg)
            OP_P:     begin mul_a = {41'd0, c_reg}; mul_b = {44'd0, s_reg}; mreq.sh = SH_16; end
            OP_T:     begin mul_a = {24'd0, dpc_reg}; mul_b = p_reg; mreq.sh = SH_16; end
            OP_W:     begin mul_a = curr64; mul_b = K_RADS; mreq.sh = SH_32; end
            OP_W2:    begin mul_a = w_reg; mul_b = w_reg; mreq.sh = SH_16; end
            OP_ROTOR: begin mul_a = w2_reg; mul_b = drag_reg; mreq.sh = SH_40; end
            OP_WN:    begin mul_a = nom64 <<< 16; mul_b = K_RADS; mreq.sh = SH_32; end
            OP_WN2:   begin mul_a = wn_reg; mul_b = wn_reg; mreq.sh = SH_16; end
            OP_AUTOT:
            begin
                mul_a = wn2_reg;
                mul_b = {23'd0, {1'b0, dic_reg} + {1'b0, dpc_reg}};
                mreq.sh = SH_40;
            end
            OP_D1:
            begin
                mul_a = {{(64-DESC_W){desc_reg[DESC_W-1]}}, desc_reg};
                mul_b = autot_reg;
                mreq.sh = SH_16;
            end
            OP_DESC:  begin mul_a = tmp_reg; mul_b = K_INV53; mreq.sh = SH_32; end
            OP_G1:    begin mul_a = {32'd0, emax_reg}; mul_b = {47'd0, thr_reg}; mreq.sh = SH_16; end
            OP_GT:    begin mul_a = tmp_reg; mul_b = K_1P2; mreq.sh = SH_32; end
            OP_LHS:   begin mul_a = nom64 <<< 16; mul_b = thr10; mreq.sh = SH_0; end
            OP_E1:    begin mul_a = {32'd0, emax_reg}; mul_b = runup64; mreq.sh = SH_16; end
            OP_ENG:   begin mul_a = tmp_reg; mul_b = K_0P333; mreq.sh = SH_32; end
            OP_HOLD:  begin mul_a = wn2_reg; mul_b = drag_reg; mreq.sh = SH_40; end
            OP_RPM:   begin mul_a = sum_reg; mul_b = {56'd0, accel_reg}; mreq.sh = SH_0; end
            OP_DELTA: begin mul_a = rpm_reg; mul_b = {32'd0, dt_reg}; mreq.sh = SH_32; end
            default:  begin mul_a = 64'sd0; mul_b = 64'sd0; mreq.sh = SH_0; end
        endcase
    end

    // Drive input and spool-down decision
    always_comb
    begin
        hold_lim  = (nom64 - 64'sd100) <<< 16;
        hold_cond = (runup_reg >= RUN_ONE) && (curr64 > hold_lim);
        rhs       = (curr64 <<< 17) + (curr64 <<< 16);
        if (gas_reg)
        begin
            inp      = (thr_reg > THR_LOW && lhs_reg > rhs) ? torque_reg : 64'sd0;
            spool    = (thr_reg <= THR_LOW) && (curr64 < SPOOL_LIM);
            sum_next = clamp_pm61(inp) + clamp_pm61(descent_reg - rotor_reg);
        end
        else
        begin
            if (hold_cond)
                inp = hold_reg;
            else if (runup_reg <= 20'sd0)
                inp = descent_reg;
            else
                inp = clamp_pm61(eng_reg) + clamp_0_61(descent_reg);
            spool    = (runup_reg <= 20'sd0) && (curr64 < SPOOL_LIM);
            sum_next = clamp_pm61(inp) - clamp_0_61(rotor_reg);
        end
    end

    // Apply the speed step with limits
    always_comb
    begin
        if (delta_reg < -LIM40)
            dcl = -LIM40;
        else if (delta_reg > LIM40)
            dcl = LIM40;
        else
            dcl = delta_reg;
        speed_sum = curr64 + dcl;
        if (speed_sum < -SPEED_MAX)
            speed_new = -SPEED_MAX;
        else if (speed_sum > SPEED_MAX)
            speed_new = SPEED_MAX;
        else
            speed_new = speed_sum;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (accept) state_next = S_SQRT;
            S_SQRT:   if (sq_done) state_next = S_ISSUE;
            S_ISSUE:  state_next = S_WAIT;
            S_WAIT:
            begin
                if (mul_done)
                begin
                    case (op_reg)
                        OP_LHS:   state_next = S_DECIDE;
                        OP_ENG:   state_next = hold_cond ? S_ISSUE : S_DECIDE;
                        OP_HOLD:  state_next = S_DECIDE;
                        OP_DELTA: state_next = S_FINISH;
                        default:  state_next = S_ISSUE;
                    endcase
                end
            end
            S_DECIDE: state_next = S_ISSUE;
            S_FINISH: if (!m_tvalid_reg || m_tready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Control state, persistent state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            op_reg       <= OP_P;
            nom_reg      <= 12'd1500;
            dic_reg      <= 40'd0;
            dpc_reg      <= 40'd0;
            emax_reg     <= 32'd0;
            dt_reg       <= 32'd10737418;
            gas_reg      <= 1'b0;
            curr_reg     <= '0;
            runup_reg    <= '0;
            mode_reg     <= MODE_NONE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Configuration writes
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_NOMINAL:    nom_reg  <= cfg_data[11:0];
                    REG_DRAG_IDLE:  dic_reg  <= cfg_data[39:0];
                    REG_DRAG_PITCH: dpc_reg  <= cfg_data[39:0];
                    REG_ENG_MAX:    emax_reg <= cfg_data[31:0];
                    REG_TICK:       dt_reg   <= cfg_data[31:0];
                    REG_GAS:        gas_reg  <= cfg_data[0];
                    default:        ;
                endcase
            end

            // Electric drive mode advances when a word is taken outside gas mode
            if (accept && !gas_reg)
            begin
                mode_reg  <= mode_next;
                runup_reg <= runup_next;
            end

            if (state_reg == S_SQRT && sq_done)
                op_reg <= OP_P;

            // Step through the multiply sequence
            if (state_reg == S_WAIT && mul_done)
            begin
                case (op_reg)
                    OP_P:     op_reg <= OP_T;
                    OP_T:     op_reg <= OP_W;
                    OP_W:     op_reg <= OP_W2;
                    OP_W2:    op_reg <= OP_ROTOR;
                    OP_ROTOR: op_reg <= OP_WN;
                    OP_WN:    op_reg <= OP_WN2;
                    OP_WN2:   op_reg <= OP_AUTOT;
                    OP_AUTOT:
                    begin
                        if (desc_reg > 25'sd0)
                            op_reg <= OP_D1;
                        else
                            op_reg <= gas_reg ? OP_G1 : OP_E1;
                    end
                    OP_D1:    op_reg <= OP_DESC;
                    OP_DESC:  op_reg <= gas_reg ? OP_G1 : OP_E1;
                    OP_G1:    op_reg <= OP_GT;
                    OP_GT:    op_reg <= OP_LHS;
                    OP_E1:    op_reg <= OP_ENG;
                    OP_ENG:   op_reg <= OP_HOLD;
                    OP_RPM:
                    begin
                        op_reg <= OP_DELTA;
                        if (gas_reg && curr64 <= 64'sd0 && mul_r <= 64'sd0)
                            curr_reg <= '0;
                    end
                    default:  ;
                endcase
            end

            // Spool-down or acceleration step
            if (state_reg == S_DECIDE)
            begin
                if (spool)
                begin
                    op_reg <= OP_DELTA;
                    if (curr64 <= 64'sd0)
                        curr_reg <= '0;
                end
                else
                begin
                    op_reg <= OP_RPM;
                end
            end

            // Publish the result and commit the new speed
            if (state_reg == S_FINISH && (!m_tvalid_reg || m_tready))
            begin
                m_tvalid_reg <= 1'b1;
                curr_reg     <= speed_new[SPEED_W-1:0];
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            thr_reg   <= thr_c;
            c_reg     <= c_mag;
            desc_reg  <= $signed(s_tdata[64:40]);
            accel_reg <= gas_reg ? ACCEL_BASE : accel_next;
        end

        if (state_reg == S_SQRT && sq_done)
            s_reg <= sq_root;

        if (state_reg == S_WAIT && mul_done)
        begin
            case (op_reg)
                OP_P:     p_reg     <= mul_r;
                OP_T:     drag_reg  <= {24'd0, dic_reg} + mul_r;
                OP_W:     w_reg     <= mul_r;
                OP_W2:    w2_reg    <= mul_r;
                OP_ROTOR: rotor_reg <= mul_r;
                OP_WN:    wn_reg    <= mul_r;
                OP_WN2:   wn2_reg   <= mul_r;
                OP_AUTOT:
                begin
                    autot_reg <= mul_r;
                    if (desc_reg <= 25'sd0)
                        descent_reg <= 64'sd0;
                end
                OP_D1:    tmp_reg     <= mul_r;
                OP_DESC:  descent_reg <= mul_r;
                OP_G1:    tmp_reg     <= mul_r;
                OP_GT:    torque_reg  <= mul_r;
                OP_LHS:   lhs_reg     <= mul_r;
                OP_E1:    tmp_reg     <= mul_r;
                OP_ENG:   eng_reg     <= mul_r;
                OP_HOLD:  hold_reg    <= mul_r;
                OP_RPM:
                begin
                    if (gas_reg && curr64 <= 64'sd0 && mul_r <= 64'sd0)
                        rpm_reg <= 64'sd0;
                    else
                        rpm_reg <= mul_r;
                end
                OP_DELTA: delta_reg <= mul_r;
                default:  ;
            endcase
        end

        if (state_reg == S_DECIDE)
        begin
            if (!gas_reg)
                torque_reg <= inp;
            sum_reg <= sum_next;
            if (spool)
                rpm_reg <= (curr64 <= 64'sd0) ? 64'sd0 : SPOOL_DOT;
        end

        if (state_reg == S_FINISH && (!m_tvalid_reg || m_tready))
            m_tdata_reg <= {3'd0, sat32(torque_reg), speed_new[SPEED_W-1:0]};
    end

    rsm_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .radicand ({1'b0, c_mag, 16'd0}),
        .done     (sq_done),
        .root     (sq_root)
    );

    rsm_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mreq),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .result (mul_r)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ hdl/rsm_checker.sv @@
// Port-level checks on the rotor speed model, bound to the top level.
`timescale 1ns / 1ps

module rsm_checker
    import rsm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_DATA_W-1:0]   m_tdata
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word dropped or changed while stalled");

    // Busy right after taking a word
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a word is in progress");

    // No result appears in the cycle after a word is taken
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared too early");

    // Speed stays within its limit
    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[28:0]) <= 29'sd262144000) &&
                     ($signed(m_tdata[28:0]) >= -29'sd262144000))
        else $error("rotor speed outside limit");

endmodule

bind rotor_speed_model_top rsm_checker u_rsm_checker (.*);

@@ tb/tb_top.sv @@
// Self-checking testbench for the rotor speed model: stream driver, monitor and tick predictor.
`timescale 1ns / 1ps

module tb_top;
    import rsm_pkg::*;

    localparam longint CYCLE_LIMIT = 3000000;
    localparam longint ONE         = 64'sd65536;
    localparam longint I64_MAX     = 64'sh7FFFFFFFFFFFFFFF;
    localparam longint I64_MIN     = 64'sh8000000000000000;

    typedef struct {
        logic [THR_W-1:0]  thr;
        logic [COLL_W-1:0] coll;
        logic [DESC_W-1:0] desc;
    } tick_in_t;

    typedef struct {
        logic [SPEED_W-1:0]  speed;
        logic [TORQUE_W-1:0] torque;
    } tick_out_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    tick_in_t  pending_ticks[$];
    tick_out_t expected_ticks[$];
    tick_in_t  held_tick;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    bit        long_hold_req = 1'b0;
    bit        long_hold_done = 1'b0;
    int        hold_left = 0;
    int        fail_count = 0;
    longint    cycle_count = 0;

    // Predictor copy of configuration and state
    longint    nom_rpm = 1500;
    longint    drag_idle = 0;
    longint    drag_pitch = 0;
    longint    eng_max = 0;
    longint    dt_q32 = 10737418;
    bit        gas_mode = 1'b0;
    longint    speed_q = 0;
    longint    runup_q = 0;
    mode_t     drive_mode = MODE_NONE;

    rotor_speed_model_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Rounded, saturating signed product shifted right
    function automatic longint scaled_mul(longint a, longint b, int sh);
        logic         neg;
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] pr;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? 64'(-a) : 64'(a);
        ub = (b < 0) ? 64'(-b) : 64'(b);
        pr = {64'd0, ua} * {64'd0, ub};
        if (sh > 0)
            pr = (pr + (128'd1 << (sh - 1))) >> sh;
        if (pr > 128'h7FFFFFFFFFFFFFFF)
            return neg ? I64_MIN : I64_MAX;
        return neg ? -longint'(pr[63:0]) : longint'(pr[63:0]);
    endfunction

    function automatic longint limit(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Advance the rotor by one tick and return the expected word
    function automatic tick_out_t advance_rotor(tick_in_t t);
        tick_out_t o;
        longint thr, coll, dsc, curr, c, s, p, drag_b, w, w2, wn, wn2;
        longint rotor, autot, descent, torque, drive, rpm_dot, accel, delta, inc, eng;
        longint lhs, rhs;
        thr = t.thr;
        coll = longint'($signed(t.coll));
        dsc = longint'($signed(t.desc));
        curr = speed_q;
        accel = 100;
        if (thr > 65536)
            thr = 65536;
        c = (coll < 0) ? -coll : coll;
        s = longint'(int_sqrt(64'(c) << 16));
        p = scaled_mul(c, s, 16);
        drag_b = drag_idle + scaled_mul(drag_pitch, p, 16);
        w = scaled_mul(curr, K_RADS, 32);
        w2 = scaled_mul(w, w, 16);
        rotor = scaled_mul(w2, drag_b, 40);
        wn = scaled_mul(nom_rpm * ONE, K_RADS, 32);
        wn2 = scaled_mul(wn, wn, 16);
        autot = scaled_mul(wn2, drag_idle + drag_pitch, 40);
        descent = 0;
        if (dsc > 0)
            descent = scaled_mul(scaled_mul(dsc, autot, 16), K_INV53, 32);

        if (gas_mode)
        begin
            // Clutch engages only while the engine outruns the rotor
            lhs = nom_rpm * thr * 10 * ONE;
            rhs = curr * 3 * 65536;
            torque = scaled_mul(scaled_mul(eng_max, thr, 16), K_1P2, 32);
            drive = (thr > THR_LOW && lhs > rhs) ? torque : 0;
            if (thr <= THR_LOW && curr < 300 * ONE)
            begin
                rpm_dot = -40 * ONE;
                if (curr <= 0)
                begin
                    rpm_dot = 0;
                    curr = 0;
                end
            end
            else
            begin
                rpm_dot = scaled_mul(limit(drive, -LIM61, LIM61)
                                     + limit(descent - rotor, -LIM61, LIM61), accel, 0);
                if (curr <= 0 && rpm_dot <= 0)
                begin
                    rpm_dot = 0;
                    curr = 0;
                end
            end
        end
        else
        begin
            // Step the electric drive mode and run-up level
            if (thr > THR_HIGH)
                drive_mode = MODE_UNLIMITED;
            else if (drive_mode == MODE_UNLIMITED && thr > THR_LOW)
                drive_mode = MODE_WINDOW;
            else if (thr <= THR_LOW)
                drive_mode = MODE_IDLE;
            if (drive_mode == MODE_WINDOW)
                inc = (dt_q32 + (64'sd1 << 16)) >>> 17;
            else
                inc = (dt_q32 + (64'sd1 << 18)) >>> 19;
            if (drive_mode == MODE_UNLIMITED)
            begin
                if (runup_q < ONE)
                    runup_q = runup_q + inc;
                else
                    runup_q = ONE;
                if (curr < (nom_rpm - 25) * ONE)
                    accel = 250;
            end
            else
            begin
                if (runup_q > 0)
                    runup_q = runup_q - inc * 10;
                else
                    runup_q = 0;
            end
            runup_q = limit(runup_q, -(64'sd1 << 19), (64'sd1 << 19) - 1);

            eng = scaled_mul(scaled_mul(eng_max, runup_q, 16), K_0P333, 32);
            if (runup_q >= ONE && curr > (nom_rpm - 100) * ONE)
                drive = scaled_mul(wn2, drag_b, 40);
            else if (runup_q <= 0)
                drive = descent;
            else
                drive = limit(eng, -LIM61, LIM61) + limit(descent, 0, LIM61);

            if (runup_q <= 0 && curr < 300 * ONE)
            begin
                rpm_dot = -40 * ONE;
                if (curr <= 0)
                begin
                    rpm_dot = 0;
                    curr = 0;
                end
            end
            else
                rpm_dot = scaled_mul(limit(drive, -LIM61, LIM61) - limit(rotor, 0, LIM61),
                                     accel, 0);
            torque = drive;
        end

        delta = limit(scaled_mul(rpm_dot, dt_q32, 32), -LIM40, LIM40);
        curr = limit(curr + delta, -SPEED_MAX, SPEED_MAX);
        speed_q = curr;
        torque = limit(torque, I32_MIN, I32_MAX);
        o.speed = curr[SPEED_W-1:0];
        o.torque = torque[TORQUE_W-1:0];
        return o;
    endfunction

    // Drive input words from the pending queue; predict each accepted word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_ticks.push_back(advance_rotor(held_tick));
            if (!s_tvalid || s_tready)
            begin
                if (pending_ticks.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    held_tick = pending_ticks.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {7'd0, held_tick.desc, held_tick.coll, held_tick.thr};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus one long hold-off
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (long_hold_req && !long_hold_done)
        begin
            hold_left <= 900;
            long_hold_done <= 1'b1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each output word with the oldest prediction
    always @(posedge clk)
    begin
        tick_out_t e;
        if (m_tvalid && m_tready)
        begin
            if (expected_ticks.size() == 0)
            begin
                $display("%0t unexpected word: actual %h", $time, m_tdata);
                fail_count = fail_count + 1;
            end
            else
            begin
                e = expected_ticks.pop_front();
                if (m_tdata[SPEED_W-1:0] !== e.speed)
                begin
                    $display("%0t rotor_speed: expected %h actual %h",
                             $time, e.speed, m_tdata[SPEED_W-1:0]);
                    fail_count = fail_count + 1;
                end
                if (m_tdata[SPEED_W+TORQUE_W-1:SPEED_W] !== e.torque)
                begin
                    $display("%0t drive torque: expected %h actual %h",
                             $time, e.torque, m_tdata[SPEED_W+TORQUE_W-1:SPEED_W]);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    // Timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= v;
        case (idx)
            REG_NOMINAL:    nom_rpm = longint'(v[11:0]);
            REG_DRAG_IDLE:  drag_idle = longint'(v[39:0]);
            REG_DRAG_PITCH: drag_pitch = longint'(v[39:0]);
            REG_ENG_MAX:    eng_max = longint'(v[31:0]);
            REG_TICK:       dt_q32 = longint'(v[31:0]);
            REG_GAS:        gas_mode = v[0];
            default:        ;
        endcase
    endtask

    task automatic write_all(longint nom, longint di, longint dp, longint em, longint tp,
                             bit gas);
        write_reg(REG_NOMINAL, CFG_DATA_W'(nom));
        write_reg(REG_DRAG_IDLE, CFG_DATA_W'(di));
        write_reg(REG_DRAG_PITCH, CFG_DATA_W'(dp));
        write_reg(REG_ENG_MAX, CFG_DATA_W'(em));
        write_reg(REG_TICK, CFG_DATA_W'(tp));
        write_reg(REG_GAS, CFG_DATA_W'(gas));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_tick(longint thr, longint coll, longint dsc);
        tick_in_t t;
        t.thr = THR_W'(thr);
        t.coll = COLL_W'(coll);
        t.desc = DESC_W'(dsc);
        pending_ticks.push_back(t);
    endtask

    // Segments of throttle held within one band walk the drive through its modes
    task automatic push_flight(int count);
        longint thr_lo, thr_hi;
        int     left;
        left = 0;
        thr_lo = 0;
        thr_hi = 0;
        repeat (count)
        begin
            if (left == 0)
            begin
                left = $urandom_range(3, 30);
                case ($urandom_range(5))
                    0: begin thr_lo = 0;     thr_hi = 0;      end
                    1: begin thr_lo = 1;     thr_hi = 9830;   end
                    2: begin thr_lo = 9831;  thr_hi = 16384;  end
                    3: begin thr_lo = 16385; thr_hi = 65536;  end
                    4: begin thr_lo = 65536; thr_hi = 131071; end
                    default: begin thr_lo = 65536; thr_hi = 65536; end
                endcase
            end
            left = left - 1;
            if ($urandom_range(9) == 0)
                push_tick($urandom, $urandom, $urandom);
            else
                push_tick($urandom_range(thr_hi, thr_lo),
                          longint'($urandom_range(2097152)) * (($urandom_range(1)) ? 1 : -1),
                          ($urandom_range(3) == 0) ? longint'($signed(25'($urandom)))
                              : longint'($urandom_range(400000)) - 100000);
        end
    endtask

    task automatic drain_block();
        while (pending_ticks.size() != 0 || expected_ticks.size() != 0 || s_tvalid)
            @(negedge clk);
        repeat (160) @(posedge clk);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed ticks at reset configuration: field extremes and mode thresholds
        push_tick(0, 0, 0);
        push_tick(131071, 4194303, 16777215);
        push_tick(65536, -4194304, -16777216);
        push_tick(65537, 2097152, 8388608);
        repeat (4) push_tick(16385, -2097152, -8388608);
        push_tick(16384, 0, 100);
        push_tick(9831, 1, 0);
        push_tick(9830, -1, 1);
        push_tick(1, 0, -1);
        repeat (3) push_tick(0, 0, 0);
        repeat (3) push_tick(131071, 65536, 65536);
        push_tick(16000, 0, 0);
        push_tick(9000, 0, 0);
        push_tick(0, 2097152, 8388608);
        drain_block();

        for (int ph = 1; ph <= 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            case (ph)
                1: write_all(4000, 0, 0, 64'd1 << 24, 64'd1 << 30, 1'b0);
                2: write_all(1, 64'hFF_FFFF_FFFF, 64'hFF_FFFF_FFFF, 64'hFFFF_FFFF,
                             64'hFFFF_FFFF, 1'b1);
                3: write_all($urandom_range(4000, 800), $urandom_range(1 << 28),
                             $urandom_range(1 << 28), $urandom_range(1 << 26, 1 << 18),
                             $urandom_range(32'h8000_0000, 1 << 28), 1'b0);
                4: write_all(4095, 64'hFF_FFFF_FFFF, 0, 0, 1, 1'b0);
                5: write_all($urandom_range(3000, 500), $urandom_range(1 << 30),
                             $urandom_range(1 << 30), $urandom_range(1 << 28, 1 << 20),
                             $urandom_range(32'h4000_0000, 1 << 26), 1'b1);
                6: write_all($urandom_range(4000, 1), {$urandom, $urandom} >> 24,
                             {$urandom, $urandom} >> 24, $urandom, $urandom, 1'b0);
                7: write_all($urandom_range(2500, 1000), $urandom_range(1 << 24),
                             $urandom_range(1 << 26), $urandom_range(1 << 24, 1 << 16),
                             $urandom_range(1 << 31, 1 << 27), 1'b1);
                default: write_all(1500, 0, 0, 0, 10737418, 1'b0);
            endcase
            if (ph == 3)
                long_hold_req = 1'b1;
            push_flight(140);
            drain_block();
        end

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
